FILE: src/icl_pkg.sv
// Package for the INI lexer/checker: byte classes, lexer and syntax tables, codes.
package icl_pkg;

	// Width of the saturating newline counter (8 to 32)
	localparam int LINE_BITS = 16;
	localparam int OUT_LINE_W = 16;

	// Byte classes
	localparam logic [3:0] CLS_HASH  = 4'd0;
	localparam logic [3:0] CLS_BLANK = 4'd1;
	localparam logic [3:0] CLS_NL    = 4'd2;
	localparam logic [3:0] CLS_LBRK  = 4'd3;
	localparam logic [3:0] CLS_RBRK  = 4'd4;
	localparam logic [3:0] CLS_QUOTE = 4'd5;
	localparam logic [3:0] CLS_IDENT = 4'd6;
	localparam logic [3:0] CLS_OTHER = 4'd7;
	localparam logic [3:0] CLS_EQ    = 4'd8;

	// Lexer states; LEX_NONE marks a missing move
	localparam logic [2:0] LEX_WS      = 3'd0;
	localparam logic [2:0] LEX_COMMENT = 3'd1;
	localparam logic [2:0] LEX_IDENT   = 3'd2;
	localparam logic [2:0] LEX_HEADER  = 3'd3;
	localparam logic [2:0] LEX_VALUE   = 3'd4;
	localparam logic [2:0] LEX_EQ      = 3'd5;
	localparam logic [2:0] LEX_NONE    = 3'd7;

	// Syntax states; SYN_NONE marks a rejected token
	localparam logic [2:0] SYN_EMPTY  = 3'd0;
	localparam logic [2:0] SYN_HEADER = 3'd1;
	localparam logic [2:0] SYN_IDENT  = 3'd2;
	localparam logic [2:0] SYN_EQ     = 3'd3;
	localparam logic [2:0] SYN_NONE   = 3'd7;

	// Token kinds
	localparam logic [1:0] TOK_IDENT  = 2'd0;
	localparam logic [1:0] TOK_HEADER = 2'd1;
	localparam logic [1:0] TOK_VALUE  = 2'd2;
	localparam logic [1:0] TOK_EQ     = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_LEX = 2'd1;
	localparam logic [1:0] STAT_SYN = 2'd2;

	localparam logic [7:0] CHR_BSLASH = 8'h5C;

	typedef logic [LINE_BITS-1:0] line_cnt_t;

	// Sort a byte into its class
	function automatic logic [3:0] byte_class(input logic [7:0] b);
		logic [3:0] c;
		begin
			unique case (b)
				8'h23: c = CLS_HASH;
				8'h20, 8'h09: c = CLS_BLANK;
				8'h0A: c = CLS_NL;
				8'h5B: c = CLS_LBRK;
				8'h5D: c = CLS_RBRK;
				8'h22: c = CLS_QUOTE;
				8'h3D: c = CLS_EQ;
				default: begin
					if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
							(b >= 8'h30 && b <= 8'h39) || b == 8'h5F)
						c = CLS_IDENT;
					else
						c = CLS_OTHER;
				end
			endcase
			return c;
		end
	endfunction

	// Lexer move from a state on a class
	function automatic logic [2:0] lex_next(input logic [2:0] st, input logic [3:0] cls);
		logic [2:0] row;
		logic [2:0] n;
		begin
			// codes above the last state wrap onto the first rows
			row = (st > LEX_EQ) ? st - 3'd6 : st;
			n = LEX_NONE;
			unique case (row)
				LEX_COMMENT: n = (cls == CLS_NL) ? LEX_WS : LEX_COMMENT;
				LEX_HEADER: begin
					if (cls == CLS_RBRK) n = LEX_WS;
					else if (cls == CLS_IDENT) n = LEX_HEADER;
					else n = LEX_NONE;
				end
				LEX_VALUE: n = (cls == CLS_QUOTE) ? LEX_WS : LEX_VALUE;
				default: begin
					// whitespace, identifier and equal sign share a row
					unique case (cls)
						CLS_HASH:  n = LEX_COMMENT;
						CLS_BLANK: n = LEX_WS;
						CLS_NL:    n = LEX_WS;
						CLS_LBRK:  n = LEX_HEADER;
						CLS_QUOTE: n = LEX_VALUE;
						CLS_IDENT: n = LEX_IDENT;
						CLS_EQ:    n = LEX_EQ;
						default:   n = LEX_NONE;
					endcase
				end
			endcase
			return n;
		end
	endfunction

	// Syntax move from a state on an ended token
	function automatic logic [2:0] syn_next(input logic [1:0] st, input logic [1:0] kind);
		logic [2:0] n;
		begin
			n = SYN_NONE;
			unique case (st)
				SYN_EMPTY[1:0]:  n = (kind == TOK_HEADER) ? SYN_HEADER : SYN_NONE;
				SYN_HEADER[1:0]: begin
					if (kind == TOK_IDENT) n = SYN_IDENT;
					else if (kind == TOK_HEADER) n = SYN_HEADER;
					else n = SYN_NONE;
				end
				SYN_IDENT[1:0]:  n = (kind == TOK_EQ) ? SYN_EQ : SYN_NONE;
				default:         n = (kind == TOK_VALUE) ? SYN_HEADER : SYN_NONE;
			endcase
			return n;
		end
	endfunction

endpackage

FILE: src/icl_in_if.sv
// Byte request channel of the INI lexer/checker.
interface icl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

FILE: src/icl_out_if.sv
// Result request channel of the INI lexer/checker.
interface icl_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  text_byte;
	logic        text_keep;
	logic        token_end;
	logic [1:0]  token_kind;
	logic [1:0]  status;
	logic [15:0] line_number;

	modport source (output valid, output text_byte, output text_keep, output token_end,
		output token_kind, output status, output line_number, input ready);
	modport sink (input valid, input text_byte, input text_keep, input token_end,
		input token_kind, input status, input line_number, output ready);
endinterface

FILE: src/ini_config_lexer_checker.sv
// Top level of the INI lexer and syntax checker, one byte per request.
// An accepted byte waits in the input stage, and its result in the result register.
// Throughput: one byte per cycle; stalls only when the result register is
// full and not being taken.
// Reset (arst_n low, async): lexer in whitespace, syntax empty, line count
// zero, status ok, both pipeline registers empty.
module ini_config_lexer_checker (
	input logic clk,
	input logic arst_n,
	icl_in_if.sink bytes,
	icl_out_if.source tokens
);
	import icl_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// lexer state
	logic [2:0] lex_q;
	logic [1:0] syn_q;
	logic       bslash_q;
	line_cnt_t  line_q;
	logic [1:0] err_q;

	// result register
	logic        valid_s2;
	logic [7:0]  byte_s2;
	logic        keep_s2;
	logic        end_s2;
	logic [1:0]  kind_s2;
	logic [1:0]  stat_s2;
	logic [15:0] line_s2;

	logic advance;

	// next-state values
	logic [2:0]  lex_d;
	logic [1:0]  syn_d;
	logic        bslash_d;
	line_cnt_t   line_d;
	logic [1:0]  err_d;
	logic        keep_d;
	logic        end_d;
	logic [1:0]  kind_d;
	logic [15:0] line_out_d;

	assign advance = valid_s1 && (!valid_s2 || tokens.ready);
	assign bytes.ready = !valid_s1 || advance;

	// Lexer and syntax step on the byte in the input stage
	always_comb begin
		logic [3:0] cls;
		logic [2:0] nxt;
		logic [2:0] snx;
		logic [31:0] line_wide;
		cls = byte_class(byte_s1);
		nxt = lex_next(lex_q, cls);
		snx = SYN_NONE;
		lex_d = lex_q;
		syn_d = syn_q;
		bslash_d = bslash_q;
		line_d = line_q;
		err_d = err_q;
		keep_d = 1'b0;
		end_d = 1'b0;
		kind_d = TOK_IDENT;
		if (err_q == STAT_OK) begin
			// newline counts even when it causes an error
			if (cls == CLS_NL && line_q != {LINE_BITS{1'b1}})
				line_d = line_q + line_cnt_t'(1);
			if (nxt == LEX_NONE) begin
				err_d = STAT_LEX;
			end else begin
				// escaped quote stays inside the value
				if (cls == CLS_QUOTE && lex_q == LEX_VALUE && bslash_q)
					nxt = LEX_VALUE;
				keep_d = (nxt == LEX_IDENT) ||
					((nxt == LEX_HEADER || nxt == LEX_VALUE) && nxt == lex_q);
				if (lex_q >= LEX_IDENT && lex_q <= LEX_EQ && nxt != lex_q) begin
					end_d = 1'b1;
					kind_d = 2'(lex_q - LEX_IDENT);
					snx = syn_next(syn_q, kind_d);
				end
				if (end_d && snx == SYN_NONE) begin
					err_d = STAT_SYN;
					keep_d = 1'b0;
				end else begin
					if (end_d)
						syn_d = snx[1:0];
					lex_d = nxt;
					bslash_d = (byte_s1 == CHR_BSLASH);
				end
			end
		end
		line_wide = 32'(line_d);
		line_out_d = (|(line_wide >> OUT_LINE_W)) ? {OUT_LINE_W{1'b1}} : line_wide[15:0];
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready)
			byte_s1 <= bytes.in_byte;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q <= LEX_WS;
			syn_q <= SYN_EMPTY[1:0];
			bslash_q <= 1'b0;
			line_q <= '0;
			err_q <= STAT_OK;
		end else if (advance) begin
			lex_q <= lex_d;
			syn_q <= syn_d;
			bslash_q <= bslash_d;
			line_q <= line_d;
			err_q <= err_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (tokens.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2 <= byte_s1;
			keep_s2 <= keep_d;
			end_s2 <= end_d;
			kind_s2 <= kind_d;
			stat_s2 <= err_d;
			line_s2 <= line_out_d;
		end
	end

	assign tokens.valid = valid_s2;
	assign tokens.text_byte = byte_s2;
	assign tokens.text_keep = keep_s2;
	assign tokens.token_end = end_s2;
	assign tokens.token_kind = kind_s2;
	assign tokens.status = stat_s2;
	assign tokens.line_number = line_s2;

`ifndef SYNTHESIS
	// an error result never keeps text
	a_err_no_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && stat_s2 != STAT_OK) |-> !keep_s2)
		else $error("text kept on an error result");

	// errors are sticky
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != STAT_OK) |=> (err_q == $past(err_q)))
		else $error("error status changed after an error");

	// no kind without a token end
	a_kind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !end_s2) |-> (kind_s2 == TOK_IDENT))
		else $error("token kind set without token end");

	// lexer state stays within the six states
	a_lex_range: assert property (@(posedge clk) disable iff (!arst_n)
		lex_q <= LEX_EQ)
		else $error("lexer state out of range");
`endif

endmodule

FILE: tb/sv/ini_config_lexer_checker_tb.sv
// Self-checking testbench for the INI lexer/checker: byte stream in, token results out.
`timescale 1ns / 1ps

module ini_config_lexer_checker_tb;
	import icl_pkg::*;

	localparam int         RANDOM_BYTES   = 1000;
	localparam int         STALL_LIMIT    = 2000;
	localparam int         SETTLE_CYCLES  = 8;
	localparam int         MAX_PRINTED    = 40;
	localparam logic [7:0] CHR_QUOTE      = 8'h22;

	typedef struct packed {
		logic [7:0]  text_byte;
		logic        text_keep;
		logic        token_end;
		logic [1:0]  token_kind;
		logic [1:0]  status;
		logic [15:0] line_number;
	} lex_result_t;

	// Predicts each result of the lexer and matches it against what comes out
	class lexer_scoreboard;
		lex_result_t expected_q[$];
		int          lex_st;
		int          syn_st;
		bit          after_bslash;
		line_cnt_t   lines;
		logic [1:0]  err;
		int          mismatches;
		int          results_seen;
		int          tokens_ended;

		function new();
			lex_st       = LEX_WS;
			syn_st       = SYN_EMPTY;
			after_bslash = 1'b0;
			lines        = '0;
			err          = STAT_OK;
			mismatches   = 0;
			results_seen = 0;
			tokens_ended = 0;
		endfunction

		function logic [3:0] classify(logic [7:0] b);
			case (b) inside
				"#":       return CLS_HASH;
				" ", "\t": return CLS_BLANK;
				"\n":      return CLS_NL;
				"[":       return CLS_LBRK;
				"]":       return CLS_RBRK;
				"\"":      return CLS_QUOTE;
				"=":       return CLS_EQ;
				default: begin
					if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
							(b >= "0" && b <= "9") || b == "_")
						return CLS_IDENT;
					return CLS_OTHER;
				end
			endcase
		endfunction

		// Lexer move; -1 when the class has no move from this state
		function int lex_move(int st, logic [3:0] cls);
			int nxt;
			nxt = -1;
			case (st)
				LEX_COMMENT: nxt = (cls == CLS_NL) ? LEX_WS : LEX_COMMENT;
				LEX_VALUE:   nxt = (cls == CLS_QUOTE) ? LEX_WS : LEX_VALUE;
				LEX_HEADER: begin
					if (cls == CLS_RBRK)
						nxt = LEX_WS;
					else if (cls == CLS_IDENT)
						nxt = LEX_HEADER;
				end
				default: begin
					// whitespace, identifier and equal sign behave alike
					case (cls) inside
						CLS_HASH:          nxt = LEX_COMMENT;
						CLS_BLANK, CLS_NL: nxt = LEX_WS;
						CLS_LBRK:          nxt = LEX_HEADER;
						CLS_QUOTE:         nxt = LEX_VALUE;
						CLS_IDENT:         nxt = LEX_IDENT;
						CLS_EQ:            nxt = LEX_EQ;
						default:           nxt = -1;
					endcase
				end
			endcase
			return nxt;
		endfunction

		// Token order: header first, then identifier = value pairs or headers
		function int syn_move(int st, logic [1:0] kind);
			int nxt;
			nxt = -1;
			case (st)
				SYN_EMPTY:  if (kind == TOK_HEADER) nxt = SYN_HEADER;
				SYN_HEADER: begin
					if (kind == TOK_IDENT)
						nxt = SYN_IDENT;
					else if (kind == TOK_HEADER)
						nxt = SYN_HEADER;
				end
				SYN_IDENT:  if (kind == TOK_EQ) nxt = SYN_EQ;
				SYN_EQ:     if (kind == TOK_VALUE) nxt = SYN_HEADER;
				default:    nxt = -1;
			endcase
			return nxt;
		endfunction

		// Step the predicted lexer with an accepted byte
		function void note_byte(logic [7:0] b);
			lex_result_t r;
			logic [3:0]  cls;
			int          nxt;
			int          syn;
			r = '0;
			r.text_byte = b;
			if (err == STAT_OK) begin
				cls = classify(b);
				if (cls == CLS_NL && lines != '1)
					lines++;
				nxt = lex_move(lex_st, cls);
				if (nxt < 0) begin
					err = STAT_LEX;
				end else begin
					// escaped quote stays inside the value
					if (b == CHR_QUOTE && lex_st == LEX_VALUE && after_bslash)
						nxt = LEX_VALUE;
					r.text_keep = (nxt == LEX_IDENT) ||
						((nxt == LEX_HEADER || nxt == LEX_VALUE) && nxt == lex_st);
					if (lex_st >= LEX_IDENT && nxt != lex_st) begin
						r.token_end  = 1'b1;
						r.token_kind = 2'(lex_st - LEX_IDENT);
						tokens_ended++;
						syn = syn_move(syn_st, r.token_kind);
						if (syn < 0) begin
							err         = STAT_SYN;
							r.text_keep = 1'b0;
						end else begin
							syn_st = syn;
						end
					end
					if (err == STAT_OK) begin
						lex_st       = nxt;
						after_bslash = (b == CHR_BSLASH);
					end
				end
			end
			r.status      = err;
			r.line_number = (32'(lines) > 32'hFFFF) ? 16'hFFFF : 16'(lines);
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < MAX_PRINTED)
				$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task cmp_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
					results_seen, name, got, want));
		endtask

		task check_result(lex_result_t got);
			lex_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing outstanding, byte %02h",
					results_seen, got.text_byte));
				return;
			end
			want = expected_q.pop_front();
			cmp_field("text_byte", 16'(got.text_byte), 16'(want.text_byte));
			cmp_field("text_keep", 16'(got.text_keep), 16'(want.text_keep));
			cmp_field("token_end", 16'(got.token_end), 16'(want.token_end));
			cmp_field("token_kind", 16'(got.token_kind), 16'(want.token_kind));
			cmp_field("status", 16'(got.status), 16'(want.status));
			cmp_field("line_number", got.line_number, want.line_number);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	icl_in_if  bytes_ch ();
	icl_out_if tokens_ch ();

	ini_config_lexer_checker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.tokens (tokens_ch)
	);

	lexer_scoreboard sb;
	logic [7:0]      text_q[$];
	bit              idle_on;
	int              idle_cycles;
	int              header_lines;
	int              pair_lines;
	lex_result_t     got;

	always #5 clk = ~clk;

	// Monitor both channels; results are checked before the new byte is noted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if (tokens_ch.valid && tokens_ch.ready) begin
				got.text_byte   = tokens_ch.text_byte;
				got.text_keep   = tokens_ch.text_keep;
				got.token_end   = tokens_ch.token_end;
				got.token_kind  = tokens_ch.token_kind;
				got.status      = tokens_ch.status;
				got.line_number = tokens_ch.line_number;
				sb.check_result(got);
			end
			if (bytes_ch.valid && bytes_ch.ready)
				sb.note_byte(bytes_ch.in_byte);
			if ((tokens_ch.valid && tokens_ch.ready) || (bytes_ch.valid && bytes_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog on requests that stop moving
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Result side: random stalls before each request while idling is on
	initial begin
		int stall;
		tokens_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 6) : 0;
			if (stall != 0) begin
				tokens_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tokens_ch.ready <= 1'b1;
			@(posedge clk);
			while (!tokens_ch.valid)
				@(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			bytes_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_ch.valid   <= 1'b1;
		bytes_ch.in_byte <= b;
		@(posedge clk);
		while (!bytes_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i]);
		text_q.delete();
	endtask

	// Stop sending until every outstanding result has come back
	task automatic drain();
		bytes_ch.valid <= 1'b0;
		// the monitor notes the last accepted byte at this edge
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic void push_blanks(int most);
		repeat ($urandom_range(0, most))
			text_q.push_back($urandom_range(0, 1) ? " " : "\t");
	endfunction

	function automatic void push_ident(int lo, int hi);
		int k;
		repeat ($urandom_range(lo, hi)) begin
			k = $urandom_range(0, 62);
			if (k < 26)
				text_q.push_back(8'("A" + k));
			else if (k < 52)
				text_q.push_back(8'("a" + k - 26));
			else if (k < 62)
				text_q.push_back(8'("0" + k - 52));
			else
				text_q.push_back("_");
		end
	endfunction

	function automatic void push_comment();
		logic [7:0] c;
		text_q.push_back("#");
		repeat ($urandom_range(0, 8)) begin
			c = 8'($urandom_range(0, 255));
			text_q.push_back((c == "\n") ? "#" : c);
		end
	endfunction

	// One well-formed line: header, key/value pair, comment or blank
	function automatic void gen_line();
		int         pick;
		logic [7:0] c;
		pick = $urandom_range(0, 9);
		push_blanks(2);
		case (pick) inside
			0, 1: begin
				header_lines++;
				text_q.push_back("[");
				push_ident(0, 8);
				text_q.push_back("]");
			end
			8: push_comment();
			9: ;
			default: begin
				pair_lines++;
				push_ident(1, 8);
				push_blanks(2);
				repeat ($urandom_range(1, 3))
					text_q.push_back("=");
				push_blanks(2);
				text_q.push_back(CHR_QUOTE);
				repeat ($urandom_range(0, 10)) begin
					c = 8'($urandom_range(0, 255));
					// keep stray quotes inside the value by escaping them
					if (c == CHR_QUOTE && text_q[$] != CHR_BSLASH)
						text_q.push_back(CHR_BSLASH);
					text_q.push_back(c);
				end
				if (text_q[$] == CHR_BSLASH)
					text_q.push_back("x");
				text_q.push_back(CHR_QUOTE);
			end
		endcase
		push_blanks(2);
		if (pick != 8 && $urandom_range(0, 3) == 0)
			push_comment();
		text_q.push_back("\n");
	endfunction

	initial begin
		bit paused;
		sb               = new();
		idle_on          = 1'b1;
		paused           = 1'b0;
		header_lines     = 0;
		pair_lines       = 0;
		bytes_ch.valid   = 1'b0;
		bytes_ch.in_byte = 8'h00;
		arst_n           = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: header, repeated '=', extreme bytes, escaped quote, comment
		push_str("[a_Z09]\nk\t==");
		text_q.push_back(CHR_QUOTE);
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		text_q.push_back(CHR_BSLASH);
		text_q.push_back(CHR_QUOTE);
		text_q.push_back(CHR_QUOTE);
		push_str(" #");
		text_q.push_back(8'h7F);
		text_q.push_back(8'h80);
		text_q.push_back("\n");
		send_text();

		// Random well-formed text, idling switched on and off in stretches
		while (sb.results_seen + sb.expected_q.size() < RANDOM_BYTES) begin
			if ($urandom_range(0, 15) == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			if (!paused && sb.expected_q.size() + sb.results_seen > RANDOM_BYTES / 2) begin
				drain();
				paused = 1'b1;
			end
			gen_line();
			send_text();
		end

		// A few more lines with idling on
		idle_on = 1'b1;
		repeat (4) gen_line();
		send_text();

		// Break the stream; the first error freezes everything after it
		case ($urandom_range(0, 4))
			0: push_str("k v ");
			1: push_str("]");
			2: push_str("[ab!");
			3: text_q.push_back(8'($urandom_range(128, 255)));
			default: push_str("= \"x\"");
		endcase
		repeat (24) text_q.push_back(8'($urandom_range(0, 255)));
		send_text();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d header and %0d key/value lines, %0d tokens ended, %0d results checked.",
			header_lines, pair_lines, sb.tokens_ended, sb.results_seen);
		$display("Stream broken at the end with status %0d at line %0d.",
			sb.err, sb.lines);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
src/icl_pkg.sv
src/icl_in_if.sv
src/icl_out_if.sv
src/ini_config_lexer_checker.sv
tb/sv/ini_config_lexer_checker_tb.sv
